>>> rtl/ctbs_pkg.sv
// Shared constants and a bit time function for the CAN bit timing search block.
package ctbs_pkg;

    // Width of the shared divider; one billion fits in 30 bits.
    localparam int DIV_W = 30;
    localparam logic [DIV_W-1:0] NS_PER_SEC = 30'd1000000000;

    localparam int PCLK_W = 29;
    localparam logic [PCLK_W-1:0] PCLK_RESET = 29'd36000000;

    localparam int TARGET_W = 13;
    localparam int ERR_W = 13;
    localparam int NQ_W = 5;
    localparam int SEG1_W = 5;
    localparam int SEG2_W = 4;
    localparam int PRESC_OUT_W = 8;

    localparam logic [SEG1_W-1:0] SEG1_LIMIT = 5'd16;
    localparam logic [SEG1_W-1:0] SEG2_LIMIT = 5'd8;
    localparam logic [ERR_W-1:0] ERR_MAX = 13'd8191;

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_NONE = 1'b1;

    localparam logic [1:0] BAUD_125K = 2'd0;
    localparam logic [1:0] BAUD_250K = 2'd1;
    localparam logic [1:0] BAUD_500K = 2'd2;
    localparam logic [1:0] BAUD_1M = 2'd3;

    // Nominal bit time in nanoseconds for each selectable bit rate.
    function automatic logic [TARGET_W-1:0] target_ns(input logic [1:0] sel);
        logic [TARGET_W-1:0] t;
        case (sel)
            BAUD_125K: t = 13'd8000;
            BAUD_250K: t = 13'd4000;
            BAUD_500K: t = 13'd2000;
            BAUD_1M: t = 13'd1000;
            default: t = 13'd1000;
        endcase
        return t;
    endfunction

endpackage

>>> rtl/ctbs_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module ctbs_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [ctbs_pkg::DIV_W-1:0] dividend,
    input  logic [ctbs_pkg::DIV_W-1:0] divisor,
    output logic                       done,
    output logic [ctbs_pkg::DIV_W-1:0] quotient
);
    import ctbs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] den_reg, den_next;
    logic [DIV_W:0]   shifted;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign fits = shifted >= {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next = CNT_W'(DIV_W - 1);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end else if (busy_reg) begin
            // The remainder stays below the divisor, so the difference fits.
            rem_next = fits ? DIV_W'(shifted - {1'b0, den_reg}) : shifted[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/can_bit_timing_search.sv
// Top level of the CAN bit timing search: sequencer around a shared divider.
//
//   Channel   Direction  Ports                                       Beat
//   request   in         s_valid, s_ready, s_baud_select             one bit rate choice
//   result    out        m_valid, m_ready, m_status, m_prescaler_out,
//                        m_seg1_quanta, m_seg2_quanta, m_error_ns    one timing answer
//   config    in         cfg_wr_en, cfg_wr_data                      peripheral clock in Hz
//
// Each prescaler trial runs up to three divisions on one 30-bit divider at one
// quotient bit per cycle, plus an evaluation step. The sweep covers prescalers 1
// to MAX_PRESCALER; a trial that hits zero error ends the sweep early.
// Reset is synchronous and active low; it restores the clock register to
// 36 MHz and empties the result register. A stalled result beat holds in the
// output register while the next request is already accepted and searched.
module can_bit_timing_search #(
    parameter int MAX_PRESCALER = 255,
    parameter int MIN_QUANTA = 8,
    parameter int MAX_QUANTA = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ctbs_pkg::PCLK_W-1:0]      cfg_wr_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [1:0]                       s_baud_select,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_status,
    output logic [ctbs_pkg::PRESC_OUT_W-1:0] m_prescaler_out,
    output logic [ctbs_pkg::SEG1_W-1:0]      m_seg1_quanta,
    output logic [ctbs_pkg::SEG2_W-1:0]      m_seg2_quanta,
    output logic [ctbs_pkg::ERR_W-1:0]       m_error_ns
);
    import ctbs_pkg::*;

    localparam int PW = $clog2(MAX_PRESCALER + 1);
    localparam int ACT_W = TARGET_W + NQ_W;

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CLK = 3'd1;
    localparam logic [2:0] ST_TQ = 3'd2;
    localparam logic [2:0] ST_NQ = 3'd3;
    localparam logic [2:0] ST_EVAL = 3'd4;
    localparam logic [2:0] ST_OUT = 3'd5;

    logic [2:0]          st_reg, st_next;
    logic [PCLK_W-1:0]   pclk_reg;
    logic [1:0]          sel_reg, sel_next;
    logic [PW-1:0]       p_reg, p_next;
    logic [TARGET_W-1:0] tq_reg, tq_next;
    logic [NQ_W-1:0]     nq_reg, nq_next;
    logic                nq_ok_reg, nq_ok_next;

    logic                found_reg, found_next;
    logic [ERR_W-1:0]    best_err_reg, best_err_next;
    logic [PW-1:0]       best_p_reg, best_p_next;
    logic [SEG1_W-1:0]   best_s1_reg, best_s1_next;
    logic [SEG2_W-1:0]   best_s2_reg, best_s2_next;

    logic                div_start_reg, div_start_next;
    logic [DIV_W-1:0]    div_num_reg, div_num_next;
    logic [DIV_W-1:0]    div_den_reg, div_den_next;
    logic                div_done;
    logic [DIV_W-1:0]    div_quo;

    logic                m_valid_reg, m_valid_next;
    logic                m_status_reg, m_status_next;
    logic [PRESC_OUT_W-1:0] m_presc_reg, m_presc_next;
    logic [SEG1_W-1:0]   m_s1_reg, m_s1_next;
    logic [SEG2_W-1:0]   m_s2_reg, m_s2_next;
    logic [ERR_W-1:0]    m_err_reg, m_err_next;

    // Evaluation of one candidate from the stored quanta count and quantum.
    logic [TARGET_W-1:0] target;
    logic [6:0]          nq_x3;
    logic [SEG1_W-1:0]   s1;
    logic [SEG1_W-1:0]   s2_wide;
    logic                seg_ok;
    logic [ACT_W-1:0]    actual;
    logic [ACT_W-1:0]    err_full;
    logic [ERR_W-1:0]    err_sat;
    logic                take;
    logic                p_last;
    logic [PW-1:0]       p_inc;
    logic [PW+PRESC_OUT_W-1:0] best_p_ext;

    ctbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_num_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign target = target_ns(sel_reg);
    assign nq_x3 = {2'b00, nq_reg} * 7'd3;
    assign s1 = nq_x3[6:2];
    assign s2_wide = nq_reg - s1 - 1'b1;
    // Segment 1 within 1..16, at least one quantum left for sync, and
    // segment 2 within 1..8.
    assign seg_ok = nq_ok_reg && (s1 >= 5'd1) && (s1 <= SEG1_LIMIT) && (nq_reg > s1)
                    && (s2_wide >= 5'd1) && (s2_wide <= SEG2_LIMIT);
    assign actual = {{NQ_W{1'b0}}, tq_reg} * {{TARGET_W{1'b0}}, nq_reg};
    assign err_full = (actual > {{NQ_W{1'b0}}, target})
                      ? actual - {{NQ_W{1'b0}}, target}
                      : {{NQ_W{1'b0}}, target} - actual;
    assign err_sat = (err_full > {{NQ_W{1'b0}}, ERR_MAX}) ? ERR_MAX : err_full[ERR_W-1:0];
    assign take = seg_ok && (!found_reg || (err_sat < best_err_reg));
    assign p_last = (p_reg == PW'(MAX_PRESCALER));
    assign p_inc = p_reg + 1'b1;
    assign best_p_ext = {{PRESC_OUT_W{1'b0}}, best_p_reg};

    always_comb begin
        st_next = st_reg;
        sel_next = sel_reg;
        p_next = p_reg;
        tq_next = tq_reg;
        nq_next = nq_reg;
        nq_ok_next = nq_ok_reg;
        found_next = found_reg;
        best_err_next = best_err_reg;
        best_p_next = best_p_reg;
        best_s1_next = best_s1_reg;
        best_s2_next = best_s2_reg;
        div_start_next = 1'b0;
        div_num_next = div_num_reg;
        div_den_next = div_den_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_presc_next = m_presc_reg;
        m_s1_next = m_s1_reg;
        m_s2_next = m_s2_reg;
        m_err_next = m_err_reg;

        case (st_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    // Start the sweep at prescaler 1: divided clock = pclk / 1.
                    sel_next = s_baud_select;
                    p_next = PW'(1);
                    found_next = 1'b0;
                    best_err_next = '0;
                    best_p_next = '0;
                    best_s1_next = '0;
                    best_s2_next = '0;
                    div_start_next = 1'b1;
                    div_num_next = {{(DIV_W-PCLK_W){1'b0}}, pclk_reg};
                    div_den_next = DIV_W'(1);
                    st_next = ST_CLK;
                end
            end
            ST_CLK: begin
                if (div_done) begin
                    if (div_quo == '0) begin
                        // Divided clock of zero: this prescaler gives no quantum.
                        if (p_last) begin
                            st_next = ST_OUT;
                        end else begin
                            p_next = p_inc;
                            div_start_next = 1'b1;
                            div_num_next = {{(DIV_W-PCLK_W){1'b0}}, pclk_reg};
                            div_den_next = {{(DIV_W-PW){1'b0}}, p_inc};
                        end
                    end else begin
                        div_start_next = 1'b1;
                        div_num_next = NS_PER_SEC;
                        div_den_next = div_quo;
                        st_next = ST_TQ;
                    end
                end
            end
            ST_TQ: begin
                if (div_done) begin
                    if (div_quo == '0) begin
                        if (p_last) begin
                            st_next = ST_OUT;
                        end else begin
                            p_next = p_inc;
                            div_start_next = 1'b1;
                            div_num_next = {{(DIV_W-PCLK_W){1'b0}}, pclk_reg};
                            div_den_next = {{(DIV_W-PW){1'b0}}, p_inc};
                            st_next = ST_CLK;
                        end
                    end else begin
                        // Only the low bits matter: a usable quantum never
                        // exceeds the target bit time.
                        tq_next = div_quo[TARGET_W-1:0];
                        div_start_next = 1'b1;
                        div_num_next = {{(DIV_W-TARGET_W){1'b0}}, target};
                        div_den_next = div_quo;
                        st_next = ST_NQ;
                    end
                end
            end
            ST_NQ: begin
                if (div_done) begin
                    nq_next = div_quo[NQ_W-1:0];
                    nq_ok_next = (div_quo >= DIV_W'(MIN_QUANTA))
                                 && (div_quo <= DIV_W'(MAX_QUANTA));
                    st_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (take) begin
                    found_next = 1'b1;
                    best_err_next = err_sat;
                    best_p_next = p_reg;
                    best_s1_next = s1;
                    best_s2_next = s2_wide[SEG2_W-1:0];
                end
                // An exact match cannot be beaten, so the sweep stops there.
                if ((take && (err_sat == '0)) || p_last) begin
                    st_next = ST_OUT;
                end else begin
                    p_next = p_inc;
                    div_start_next = 1'b1;
                    div_num_next = {{(DIV_W-PCLK_W){1'b0}}, pclk_reg};
                    div_den_next = {{(DIV_W-PW){1'b0}}, p_inc};
                    st_next = ST_CLK;
                end
            end
            ST_OUT: begin
                // Wait here until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_status_next = found_reg ? STATUS_FOUND : STATUS_NONE;
                    m_presc_next = found_reg ? best_p_ext[PRESC_OUT_W-1:0] : '0;
                    m_s1_next = found_reg ? best_s1_reg : '0;
                    m_s2_next = found_reg ? best_s2_reg : '0;
                    m_err_next = found_reg ? best_err_reg : '0;
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            pclk_reg <= PCLK_RESET;
            div_start_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (cfg_wr_en) begin
                pclk_reg <= cfg_wr_data;
            end
            div_start_reg <= div_start_next;
            m_valid_reg <= m_valid_next;
            found_reg <= found_next;
        end
        sel_reg <= sel_next;
        p_reg <= p_next;
        tq_reg <= tq_next;
        nq_reg <= nq_next;
        nq_ok_reg <= nq_ok_next;
        best_err_reg <= best_err_next;
        best_p_reg <= best_p_next;
        best_s1_reg <= best_s1_next;
        best_s2_reg <= best_s2_next;
        div_num_reg <= div_num_next;
        div_den_reg <= div_den_next;
        m_status_reg <= m_status_next;
        m_presc_reg <= m_presc_next;
        m_s1_reg <= m_s1_next;
        m_s2_reg <= m_s2_next;
        m_err_reg <= m_err_next;
    end

    assign s_ready = (st_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_prescaler_out = m_presc_reg;
    assign m_seg1_quanta = m_s1_reg;
    assign m_seg2_quanta = m_s2_reg;
    assign m_error_ns = m_err_reg;

endmodule

>>> tb/ctbs_timing_checker.sv
// Checker for the CAN bit timing search: predicts each answer and compares the result beats.
`timescale 1ns / 1ps

module ctbs_timing_checker #(
    parameter int MAX_PRESCALER = 255,
    parameter int MIN_QUANTA = 8,
    parameter int MAX_QUANTA = 25
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [ctbs_pkg::PCLK_W-1:0]      cfg_wr_data,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [1:0]                       s_baud_select,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_status,
    input  logic [ctbs_pkg::PRESC_OUT_W-1:0] m_prescaler_out,
    input  logic [ctbs_pkg::SEG1_W-1:0]      m_seg1_quanta,
    input  logic [ctbs_pkg::SEG2_W-1:0]      m_seg2_quanta,
    input  logic [ctbs_pkg::ERR_W-1:0]       m_error_ns,
    output int                               mismatch_count,
    output int                               answers_open
);

    import ctbs_pkg::*;

    typedef struct packed {
        logic                   status;
        logic [PRESC_OUT_W-1:0] prescaler;
        logic [SEG1_W-1:0]      seg1;
        logic [SEG2_W-1:0]      seg2;
        logic [ERR_W-1:0]       error_ns;
    } timing_t;

    timing_t           awaited_timings[$];
    logic [PCLK_W-1:0] pclk_copy;
    timing_t           seen;
    timing_t           want;
    logic              bad;
    logic              orphan;

    // Sweeps every prescaler and keeps the first one with the smallest bit time error.
    function automatic timing_t search_timing(input logic [1:0] sel,
                                              input logic [PCLK_W-1:0] clk_hz);
        longint unsigned rate_hz, target, clk, tq, nq, s1, s2, actual, err;
        longint unsigned best_err, best_p, best_s1, best_s2, p;
        bit found, exact;
        timing_t r;
        case (sel)
            BAUD_125K: rate_hz = 125000;
            BAUD_250K: rate_hz = 250000;
            BAUD_500K: rate_hz = 500000;
            default: rate_hz = 1000000;
        endcase
        target = 64'd1000000000 / rate_hz;
        found = 1'b0;
        exact = 1'b0;
        best_err = 0;
        best_p = 0;
        best_s1 = 0;
        best_s2 = 0;
        for (p = 1; p <= MAX_PRESCALER && !exact; p++) begin
            clk = clk_hz / p;
            // A clock below the prescaler or a sub-nanosecond quantum gives no trial.
            if (clk != 0) begin
                tq = 64'd1000000000 / clk;
                if (tq != 0) begin
                    nq = target / tq;
                    s1 = (nq * 3) / 4;
                    if (nq >= MIN_QUANTA && nq <= MAX_QUANTA && s1 >= 1 &&
                        s1 <= SEG1_LIMIT && nq >= s1 + 1) begin
                        s2 = nq - s1 - 1;
                        if (s2 >= 1 && s2 <= SEG2_LIMIT) begin
                            actual = tq * (1 + s1 + s2);
                            err = (actual > target) ? actual - target : target - actual;
                            if (!found || err < best_err) begin
                                found = 1'b1;
                                best_err = err;
                                best_p = p;
                                best_s1 = s1;
                                best_s2 = s2;
                                exact = (err == 0);
                            end
                        end
                    end
                end
            end
        end
        r = '0;
        if (!found) begin
            r.status = STATUS_NONE;
        end else begin
            if (best_err > ERR_MAX) begin
                best_err = ERR_MAX;
            end
            r.status = STATUS_FOUND;
            r.prescaler = best_p[PRESC_OUT_W-1:0];
            r.seg1 = best_s1[SEG1_W-1:0];
            r.seg2 = best_s2[SEG2_W-1:0];
            r.error_ns = best_err[ERR_W-1:0];
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pclk_copy = PCLK_RESET;
            awaited_timings.delete();
            answers_open = 0;
        end else begin
            if (cfg_wr_en) begin
                pclk_copy = cfg_wr_data;
            end
            // Retire the result beat before queuing a new request from the same edge.
            if (m_valid && m_ready) begin
                seen.status = m_status;
                seen.prescaler = m_prescaler_out;
                seen.seg1 = m_seg1_quanta;
                seen.seg2 = m_seg2_quanta;
                seen.error_ns = m_error_ns;
                orphan = (awaited_timings.size() == 0);
                if (orphan) begin
                    want = '0;
                    bad = 1'b1;
                end else begin
                    want = awaited_timings.pop_front();
                    bad = (seen !== want);
                end
                if (bad) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display("%0t result beat %s", $realtime,
                                 orphan ? "with no request" : "mismatch");
                        $display("    expected st=%0d psc=%0d s1=%0d s2=%0d err=%0d",
                                 want.status, want.prescaler, want.seg1, want.seg2,
                                 want.error_ns);
                        $display("    actual   st=%0d psc=%0d s1=%0d s2=%0d err=%0d",
                                 seen.status, seen.prescaler, seen.seg1, seen.seg2,
                                 seen.error_ns);
                    end
                end
            end
            if (s_valid && s_ready) begin
                awaited_timings.push_back(search_timing(s_baud_select, pclk_copy));
            end
            answers_open = awaited_timings.size();
        end
    end

endmodule

>>> tb/tb_can_bit_timing_search.sv
// Testbench top for the CAN bit timing search: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb_can_bit_timing_search;

    import ctbs_pkg::*;

    // All block inputs start from known values at time zero.
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [PCLK_W-1:0]      cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_baud_select = BAUD_125K;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_status;
    logic [PRESC_OUT_W-1:0] m_prescaler_out;
    logic [SEG1_W-1:0]      m_seg1_quanta;
    logic [SEG2_W-1:0]      m_seg2_quanta;
    logic [ERR_W-1:0]       m_error_ns;

    int   mismatch_count;
    int   answers_open;
    int   ready_left = 0;
    // Once set, neither side inserts idle cycles any more.
    logic fast_phase = 1'b0;

    always #5 aclk = ~aclk;

    can_bit_timing_search dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_baud_select  (s_baud_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_prescaler_out(m_prescaler_out),
        .m_seg1_quanta  (m_seg1_quanta),
        .m_seg2_quanta  (m_seg2_quanta),
        .m_error_ns     (m_error_ns)
    );

    ctbs_timing_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_baud_select  (s_baud_select),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_prescaler_out(m_prescaler_out),
        .m_seg1_quanta  (m_seg1_quanta),
        .m_seg2_quanta  (m_seg2_quanta),
        .m_error_ns     (m_error_ns),
        .mismatch_count (mismatch_count),
        .answers_open   (answers_open)
    );

    // Result side backpressure. Ready stays high in the fast phase; otherwise it
    // alternates between stall bursts and ready stretches, some of them long. Since
    // a result only shows up once per sweep, a good share of result beats lands
    // inside a stall and sits in the output register while the next search runs.
    always @(negedge aclk) begin
        if (ready_left == 0) begin
            if (fast_phase) begin
                m_ready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                ready_left <= $urandom_range(1, 12);
            end else begin
                m_ready <= 1'b1;
                ready_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                          : $urandom_range(1, 24);
            end
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    // One request beat. Outside the last phases a random gap may come first, so
    // valid also drops between beats. Valid is held until the block takes it.
    task automatic send_request(input logic [1:0] sel);
        if (!fast_phase && $urandom_range(0, 2) == 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12) - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_baud_select <= sel;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Requests every bit rate once under the current clock setting.
    task automatic sweep_rates();
        send_request(BAUD_125K);
        send_request(BAUD_250K);
        send_request(BAUD_500K);
        send_request(BAUD_1M);
    endtask

    // Lets the block drain completely before the clock register is touched, then
    // writes it with a single-cycle enable.
    task automatic set_pclk(input logic [PCLK_W-1:0] hz);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (answers_open != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= hz;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [PCLK_W-1:0] hz;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. First the reset value of the clock register, then the
        // slowest and fastest legal clocks, then a zero clock where every
        // prescaler divides down to nothing and no timing can exist, and finally
        // the all-ones register value that gives the smallest quanta at every prescaler.
        sweep_rates();
        set_pclk(29'd1000000);
        sweep_rates();
        set_pclk(29'd400000000);
        sweep_rates();
        set_pclk('0);
        send_request(BAUD_125K);
        send_request(BAUD_1M);
        set_pclk('1);
        sweep_rates();

        // Random part: ten phases of ten requests, each under a fresh clock.
        // The mix covers arbitrary legal clocks, whole-megahertz clocks (where
        // exact timings and the early sweep exit are common), raw 29-bit values
        // that flip every register bit, and very slow clocks that mostly end in
        // no solution. The last two phases run with no idling on either side.
        for (int phase = 0; phase < 10; phase++) begin
            case ($urandom_range(0, 3))
                0: hz = PCLK_W'($urandom_range(1000000, 400000000));
                1: hz = PCLK_W'($urandom);
                2: hz = PCLK_W'($urandom_range(1, 400) * 1000000);
                default: hz = PCLK_W'($urandom_range(0, 2000000));
            endcase
            set_pclk(hz);
            if (phase >= 8) begin
                fast_phase <= 1'b1;
            end
            for (int n = 0; n < 10; n++) begin
                send_request(2'($urandom_range(0, 3)));
            end
        end

        // Drain: wait for every answer, then a short tail for stray beats.
        @(negedge aclk);
        s_valid <= 1'b0;
        while (answers_open != 0) @(negedge aclk);
        repeat (64) @(negedge aclk);

        if (mismatch_count == 0 && answers_open == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog. There are under 120 requests, each costing at most one full sweep, so
    // a correct run needs roughly 30 ms; this allows several times that.
    initial begin
        #200000000;
        $display("simulation failed");
        $finish;
    end

endmodule
